[rtl/grc_pkg.sv]
// Shared types and constants for the grid ray-caster column block.
package grc_pkg;

  localparam int REG_IDX_W = 3;

  // map side in cells and fixed-point fraction bits (Q.16)
  localparam int MAP_SIZE  = 32;
  localparam int FRAC_BITS = 16;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PLAYER_X = 3'd0,
    REG_PLAYER_Y = 3'd1,
    REG_DIR_X    = 3'd2,
    REG_DIR_Y    = 3'd3,
    REG_PLANE_X  = 3'd4,
    REG_PLANE_Y  = 3'd5,
    REG_WIDTH    = 3'd6,
    REG_HEIGHT   = 3'd7
  } reg_idx_t;

  localparam logic OP_MAP_WRITE = 1'b0;
  localparam logic OP_CAST      = 1'b1;

  // Tile color table: {red, green, blue}
  function automatic logic [23:0] tile_color(input logic [2:0] code);
    logic [23:0] c;
    case (code)
      3'd1:    c = 24'hFF0000;
      3'd2:    c = 24'h00FF00;
      3'd3:    c = 24'h0000FF;
      3'd4:    c = 24'hFF00FF;
      default: c = 24'h00FFFF;
    endcase
    return c;
  endfunction

endpackage

[rtl/grid_raycast_column.sv]
// A map-write beat is written into the map as it is accepted. A cast beat raises m_tvalid
// after eight divisions through the shared restoring divider and up to 2*MAP_SIZE+2 walk
// steps (one map read each), with fewer when a ray component is zero or the walk ends
// early. One item at a time: the next beat is taken the cycle after the result beat
// leaves. Reset: synchronous active-high rst restores the configuration registers and runs
// a clearing pass over all MAP_SIZE*MAP_SIZE map cells; no beat is accepted until it ends
// (configuration writes are taken throughout).
module grid_raycast_column
  import grc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream; tuser: opcode[0]
  // tdata: cell_x[4:0], cell_y[9:5], tile_code[12:10], column[23:13]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic        s_tuser,
  input  logic [23:0] s_tdata,
  // result stream; tdata: out_column[10:0], top_row[21:11], bottom_row[32:22],
  // red[40:33], green[48:41], blue[56:49], hit_side[57], hit_outside[58], pad to 64
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [20:0] cfg_data
);

  localparam int MB     = $clog2(MAP_SIZE);
  localparam int ADDR_W = 2 * MB;
  localparam int DEPTH  = MAP_SIZE * MAP_SIZE;
  localparam int DW     = 64;                 // datapath width
  localparam int F      = FRAC_BITS;
  localparam logic signed [DW-1:0] SAT = 64'sd1 <<< 40;
  localparam logic signed [DW-1:0] ONE = 64'sd1 <<< F;
  localparam int DCW    = $clog2(DW + 1);
  localparam int MCW    = MB + 2;             // map coordinate, signed room

  // configuration registers
  logic [20:0]        px, py;
  logic signed [17:0] dx, dy, cxp, cyp;
  logic [11:0]        w_reg, h_reg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      px    <= 21'd1441792;
      py    <= 21'd786432;
      dx    <= -18'sd65536;
      dy    <= 18'sd0;
      cxp   <= 18'sd0;
      cyp   <= 18'sd43254;
      w_reg <= 12'd800;
      h_reg <= 12'd600;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_PLAYER_X: px    <= cfg_data;
        REG_PLAYER_Y: py    <= cfg_data;
        REG_DIR_X:    dx    <= cfg_data[17:0];
        REG_DIR_Y:    dy    <= cfg_data[17:0];
        REG_PLANE_X:  cxp   <= cfg_data[17:0];
        REG_PLANE_Y:  cyp   <= cfg_data[17:0];
        REG_WIDTH:    w_reg <= cfg_data[11:0];
        REG_HEIGHT:   h_reg <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic             in_op;
  logic [4:0]       in_cx, in_cy;
  logic [2:0]       in_tile;
  logic [10:0]      in_col;
  assign in_op   = s_tuser;
  assign in_cx   = s_tdata[4:0];
  assign in_cy   = s_tdata[9:5];
  assign in_tile = s_tdata[12:10];
  assign in_col  = s_tdata[23:13];

  // map memory, one write port, one registered read port
  logic [2:0]        tile_mem [DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [2:0]        mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) tile_mem[mem_waddr] <= mem_wdata;
    mem_rdata <= tile_mem[mem_raddr];
  end

  // shared restoring divider: unsigned quotient of the dividend loaded into div_q by div_d,
  // one bit per cycle
  logic [DW-1:0]  div_d, div_q, div_rem;
  logic [DCW-1:0] div_cnt;
  logic           div_busy;
  logic [DW:0]    div_trial;
  logic [DW-1:0]  div_shift;

  assign div_shift = {div_rem[DW-2:0], div_q[DW-1]};
  assign div_trial = {1'b0, div_shift} - {1'b0, div_d};

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CAM, S_RAYX, S_RAYY, S_DDX, S_DDY, S_SDX, S_SDY,
    S_WALK, S_CHECK, S_DIST, S_LH, S_HGT, S_ROWS, S_SR, S_SG, S_SB, S_OUT
  } state_t;

  state_t state;
  logic [ADDR_W:0] clr_cnt;

  // cast working registers
  logic [10:0]           col;
  logic signed [DW-1:0]  hv, cam, rx, ry, ddx, ddy, sdx, sdy, perp_dist;
  logic signed [MCW-1:0] mx, my;
  logic [6:0]            steps;
  logic                  side, outside;
  logic [2:0]            tile;
  logic [7:0]            cr, cg, cb;
  logic [10:0]           top_r, bot_r;
  logic                  div_neg;   // floor correction for negative dividend

  // shared multiplier: plane or cell fraction times camera or delta
  logic signed [17:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [51:0] mul_p;
  assign mul_p = mul_a * mul_b;

  function automatic logic [DW-1:0] abs_v(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  logic signed [DW-1:0] frac_x, frac_y, num;
  logic signed [DW-1:0] pxs, pys;
  assign pxs = DW'(px);
  assign pys = DW'(py);

  always_comb begin
    frac_x = rx[DW-1] ? pxs - (DW'(signed'(mx)) <<< F) : ((DW'(signed'(mx)) + 1) <<< F) - pxs;
    frac_y = ry[DW-1] ? pys - (DW'(signed'(my)) <<< F) : ((DW'(signed'(my)) + 1) <<< F) - pys;
    if (!side) num = (DW'(signed'(mx)) <<< F) - pxs + (rx[DW-1] ? ONE : '0);
    else       num = (DW'(signed'(my)) <<< F) - pys + (ry[DW-1] ? ONE : '0);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_RAYX: begin mul_a = cxp;         mul_b = 34'(cam); end
      S_RAYY: begin mul_a = cyp;         mul_b = 34'(cam); end
      S_SDX:  begin mul_a = 18'(frac_x); mul_b = 34'(ddx); end
      S_SDY:  begin mul_a = 18'(frac_y); mul_b = 34'(ddy); end
      default: ;
    endcase
  end

  // map walk step
  logic                  take_x;
  logic signed [MCW-1:0] mx_n, my_n;
  logic                  out_n;
  assign take_x = sdx < sdy;
  assign mx_n = take_x ? (rx[DW-1] ? mx - 1'b1 : mx + 1'b1) : mx;
  assign my_n = take_x ? my : (ry[DW-1] ? my - 1'b1 : my + 1'b1);
  assign out_n = mx_n < 0 || my_n < 0 || mx_n >= MCW'(MAP_SIZE) || my_n >= MCW'(MAP_SIZE);

  function automatic logic signed [DW-1:0] sadd(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    logic signed [DW-1:0] s;
    s = a + b;
    return s > SAT ? SAT : s;
  endfunction

  logic [23:0] base_c;
  logic [7:0]  br, bg, bb;
  assign base_c = tile_color(outside ? 3'd0 : tile);
  assign br = side ? {1'b0, base_c[23:17]} : base_c[23:16];
  assign bg = side ? {1'b0, base_c[15:9]}  : base_c[15:8];
  assign bb = side ? {1'b0, base_c[7:1]}   : base_c[7:0];

  logic signed [DW-1:0] hh, top_v, bot_v;
  assign hh    = hv >>> 1;
  assign top_v = hh - (DW'(div_q) >>> 1);
  assign bot_v = hh + (DW'(div_q) >>> 1);

  logic [DW-1:0] q_floor;
  assign q_floor = div_neg ? ((div_rem != '0) ? DW'(-(div_q + 1'b1)) : DW'(-div_q)) : div_q;

  assign s_tready = (state == S_IDLE);
  // the read is registered at the walk step, so the tile of the entered cell is ready at check
  assign mem_raddr = ADDR_W'({mx_n[MB-1:0], my_n[MB-1:0]});

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ADDR_W'({in_cx[MB-1:0], in_cy[MB-1:0]});
    mem_wdata = in_tile;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt[ADDR_W-1:0];
      mem_wdata = '0;
    end else if (state == S_IDLE && s_tvalid && in_op == OP_MAP_WRITE &&
                 32'(in_cx) < 32'(MAP_SIZE) && 32'(in_cy) < 32'(MAP_SIZE)) begin
      mem_we = 1'b1;
    end
  end

  logic [7:0] sat8;
  assign sat8 = (div_q > DW'(255)) ? 8'd255 : div_q[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      div_busy <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (div_busy) begin
        div_rem <= div_trial[DW] ? div_shift : div_trial[DW-1:0];
        div_q   <= {div_q[DW-2:0], ~div_trial[DW]};
        div_cnt <= div_cnt - 1'b1;
        if (div_cnt == DCW'(1)) div_busy <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (ADDR_W + 1)'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid && in_op == OP_CAST) begin
            col <= in_col;
            hv  <= (h_reg == '0) ? DW'(1) : DW'(h_reg);
            mx  <= MCW'(px >> F);
            my  <= MCW'(py >> F);
            // camera: ((2*col - w) << F) / w, floored
            div_neg  <= DW'({in_col, 1'b0}) < ((w_reg == '0) ? DW'(1) : DW'(w_reg));
            div_d    <= (w_reg == '0) ? DW'(1) : DW'(w_reg);
            div_q    <= abs_v((DW'({in_col, 1'b0}) - ((w_reg == '0) ? DW'(1) : DW'(w_reg))) <<< F);
            div_rem  <= '0;
            div_cnt  <= DCW'(DW);
            div_busy <= 1'b1;
            state    <= S_CAM;
          end
        end
        S_CAM: if (!div_busy) begin cam <= q_floor; state <= S_RAYX; end
        S_RAYX: begin rx <= DW'(dx) + (DW'(mul_p) >>> F); state <= S_RAYY; end
        S_RAYY: begin
          ry <= DW'(dy) + (DW'(mul_p) >>> F);
          div_q <= DW'(1) << (2 * F); div_d <= abs_v(rx); div_rem <= '0;
          div_neg <= 1'b0; div_cnt <= DCW'(DW); div_busy <= (rx != '0);
          state <= S_DDX;
        end
        S_DDX: if (!div_busy) begin
          ddx <= (rx == '0) ? SAT : div_q;
          div_q <= DW'(1) << (2 * F); div_d <= abs_v(ry); div_rem <= '0;
          div_cnt <= DCW'(DW); div_busy <= (ry != '0);
          state <= S_DDY;
        end
        S_DDY: if (!div_busy) begin
          ddy <= (ry == '0) ? SAT : div_q;
          state <= S_SDX;
        end
        S_SDX: begin sdx <= (rx == '0) ? SAT : (DW'(mul_p) >>> F); state <= S_SDY; end
        S_SDY: begin
          sdy <= (ry == '0) ? SAT : (DW'(mul_p) >>> F);
          steps <= '0; outside <= 1'b1; side <= 1'b0;
          state <= S_WALK;
        end
        S_WALK: begin
          if (take_x) begin sdx <= sadd(sdx, ddx); side <= 1'b0; end
          else begin sdy <= sadd(sdy, ddy); side <= 1'b1; end
          mx <= mx_n; my <= my_n;
          steps <= steps + 1'b1;
          state <= out_n ? S_DIST : S_CHECK;
        end
        S_CHECK: begin
          tile <= mem_rdata;
          if (mem_rdata != '0) begin outside <= 1'b0; state <= S_DIST; end
          else if (steps == 7'(2 * MAP_SIZE + 2)) state <= S_DIST;
          else state <= S_WALK;
        end
        S_DIST: begin
          div_q <= abs_v(num) << F; div_rem <= '0;
          div_d <= side ? abs_v(ry) : abs_v(rx);
          div_neg <= 1'b0; div_cnt <= DCW'(DW);
          div_busy <= side ? (ry != '0) : (rx != '0);
          state <= S_LH;
        end
        S_LH: if (!div_busy) begin
          if ((side ? ry : rx) == '0) perp_dist <= SAT;
          else perp_dist <= (div_q == '0) ? DW'(1) : div_q;
          state <= S_HGT;
        end
        S_HGT: begin
          // line height, then color channels, all divide by the distance
          div_q <= DW'(hv) << (F + 2); div_rem <= '0; div_d <= perp_dist;
          div_cnt <= DCW'(DW); div_busy <= 1'b1;
          state <= S_ROWS;
        end
        S_ROWS: if (!div_busy) begin
          top_r <= top_v < 0 ? 11'd0 : (top_v > 2047 ? 11'd2047 : top_v[10:0]);
          bot_r <= (bot_v >= hv ? (hv - 1 > 2047 ? 11'd2047 : 11'(hv - 1))
                    : (bot_v > 2047 ? 11'd2047 : bot_v[10:0]));
          div_q <= DW'(br) << (F + 3); div_rem <= '0;
          div_cnt <= DCW'(DW); div_busy <= 1'b1;
          state <= S_SR;
        end
        S_SR: if (!div_busy) begin
          cr <= sat8;
          div_q <= DW'(bg) << (F + 3); div_rem <= '0;
          div_cnt <= DCW'(DW); div_busy <= 1'b1;
          state <= S_SG;
        end
        S_SG: if (!div_busy) begin
          cg <= sat8;
          div_q <= DW'(bb) << (F + 3); div_rem <= '0;
          div_cnt <= DCW'(DW); div_busy <= 1'b1;
          state <= S_SB;
        end
        S_SB: if (!div_busy) begin
          cb <= sat8;
          m_tvalid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (m_tready) begin m_tvalid <= 1'b0; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {5'd0, outside, side, cb, cg, cr, bot_r, top_r, col};

endmodule
